// ----- rtl/lstp_pkg.sv -----
// ----------------------------------------------------------------------------
// lstp_pkg
// Shared types, codes and character tables of the scan telegram parser.
// ----------------------------------------------------------------------------
package lstp_pkg;

  localparam int unsigned PREFIX_LEN = 15;
  localparam int unsigned NAME_LEN   = 5;
  localparam int unsigned MAX_DIGITS = 8;

  localparam logic [3:0] PREFIX_LAST_POS = 4'(PREFIX_LEN);
  localparam logic [2:0] NAME_END_POS    = 3'(NAME_LEN);
  localparam logic [3:0] DIGIT_LIMIT     = 4'(MAX_DIGITS);
  localparam logic [3:0] DIGIT_SAT       = 4'(MAX_DIGITS + 1);

  // output queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_DISTANCE = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd1;
  localparam logic [2:0] ST_NO_CHANNEL = 3'd2;
  localparam logic [2:0] ST_BAD_HEADER = 3'd3;
  localparam logic [2:0] ST_TOO_FEW    = 3'd4;
  localparam logic [2:0] ST_BAD_VALUE  = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] start_ticks;
    logic [31:0] step_ticks;
    logic [31:0] point_count;
    logic [31:0] distance_mm;
    logic [31:0] point_index;
    logic [2:0]  status;
    logic        last;
  } item_t;

  // Character of prefix alternative alt (0 or 1) at position pos.
  function automatic logic [7:0] prefix_char(input logic alt, input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = 8'h73;
      4'd1:    c = alt ? 8'h52 : 8'h53;
      4'd2:    c = alt ? 8'h41 : 8'h4E;
      4'd3:    c = 8'h20;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h4D;
      4'd6:    c = 8'h44;
      4'd7:    c = 8'h73;
      4'd8:    c = 8'h63;
      4'd9:    c = 8'h61;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h64;
      4'd12:   c = 8'h61;
      4'd13:   c = 8'h74;
      4'd14:   c = 8'h61;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Channel name "DIST1".
  function automatic logic [7:0] name_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h44;
      3'd1:    c = 8'h49;
      3'd2:    c = 8'h53;
      3'd3:    c = 8'h54;
      3'd4:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

endpackage

// ----- rtl/lidar_scan_telegram_parser.sv -----
// ----------------------------------------------------------------------------
// lidar_scan_telegram_parser
// Byte-wise parser of ASCII hex scan telegrams into header, distance and
// end status items.
// ----------------------------------------------------------------------------
// One telegram character is taken per cycle while the queue has room; the
// parse state is updated in the same cycle and the items it causes go into a
// four-entry result queue. A byte closing a token yields at most one header
// or distance item, and the byte flagged with tlast adds the end status item,
// so a byte is taken whenever the queue has room for two items: with the
// output side always ready the block runs at one byte per cycle. With the
// queue empty, the first item of a byte appears at the output in the cycle
// after the byte is taken and a second item follows once the first has been
// popped; items already queued go out first. On a non-zero status the consumer
// should drop the items of that telegram.
module lidar_scan_telegram_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input items
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] byte_req
  input  logic         s_axis_tlast,   // end_of_payload
  // result items
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,   // start_ticks, step_ticks, point_count,
                                       // distance_mm, point_index, status, zero pad
  output logic [1:0]   m_axis_tuser,   // kind
  output logic         m_axis_tlast    // last
);

  localparam logic [1:0] PH_SEARCH = 2'd0;
  localparam logic [1:0] PH_HEADER = 2'd1;
  localparam logic [1:0] PH_VALUES = 2'd2;

  logic [3:0]  pos_q, pos_d;
  logic [1:0]  alive_q, alive_d;
  logic [1:0]  phase_q, phase_d;
  logic        in_tok_q, in_tok_d;
  logic [31:0] acc_q, acc_d;
  logic [3:0]  dig_q, dig_d;
  logic        inv_q, inv_d;
  logic [2:0]  npos_q, npos_d;
  logic        nmis_q, nmis_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [31:0] start_q, start_d;
  logic [31:0] step_q, step_d;
  logic [31:0] count_q, count_d;
  logic [31:0] seen_q, seen_d;
  logic        herr_q, herr_d;
  logic        verr_q, verr_d;

  logic            accept;
  logic            room2;
  logic [1:0]      push_cnt;
  lstp_pkg::item_t tok_item, end_item, item0, q_item;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = room2;

  always_comb begin
    logic [7:0]  c;
    logic        fin;
    logic        blank;
    logic        hex;
    logic [3:0]  digit;
    logic        t_in;
    logic [31:0] t_acc;
    logic [3:0]  t_dig;
    logic        t_inv;
    logic [2:0]  t_npos;
    logic        t_nmis;
    logic        close;
    logic        valid;
    logic        emit;
    logic [31:0] cnt_v;
    logic        herr_v;
    logic [2:0]  st;

    c     = s_axis_tdata;
    fin   = s_axis_tlast;
    blank = lstp_pkg::is_blank(c);

    pos_d   = pos_q;
    alive_d = alive_q;
    phase_d = phase_q;
    hidx_d  = hidx_q;
    start_d = start_q;
    step_d  = step_q;
    count_d = count_q;
    seen_d  = seen_q;
    herr_d  = herr_q;
    verr_d  = verr_q;
    emit    = 1'b0;
    tok_item = '0;
    end_item = '0;

    // prefix check
    if (pos_q < lstp_pkg::PREFIX_LAST_POS) begin
      if (c != lstp_pkg::prefix_char(1'b0, pos_q)) alive_d[0] = 1'b0;
      if (c != lstp_pkg::prefix_char(1'b1, pos_q)) alive_d[1] = 1'b0;
      pos_d = pos_q + 4'd1;
    end

    // character into the current token
    hex   = 1'b1;
    digit = 4'd0;
    if (c >= 8'h30 && c <= 8'h39)      digit = 4'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) digit = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) digit = 4'(c - 8'h57);
    else                               hex = 1'b0;

    t_in   = in_tok_q;
    t_acc  = acc_q;
    t_dig  = dig_q;
    t_inv  = inv_q;
    t_npos = npos_q;
    t_nmis = nmis_q;
    if (!blank) begin
      t_in = 1'b1;
      if (dig_q < lstp_pkg::DIGIT_SAT) t_dig = dig_q + 4'd1;
      if (!hex || t_dig > lstp_pkg::DIGIT_LIMIT) t_inv = 1'b1;
      else t_acc = {acc_q[27:0], digit};
      if (npos_q < lstp_pkg::NAME_END_POS && c == lstp_pkg::name_char(npos_q))
        t_npos = npos_q + 3'd1;
      else
        t_nmis = 1'b1;
    end

    // token close on whitespace, or at the final byte
    close = t_in && (blank || fin);
    valid = !t_inv && (t_dig != 4'd0);
    cnt_v  = valid ? t_acc : 32'd0;
    herr_v = herr_q || !valid || (cnt_v == 32'd0);

    if (close && alive_d != 2'b00) begin
      case (phase_q)
        PH_SEARCH: begin
          if (!t_nmis && t_npos == lstp_pkg::NAME_END_POS) begin
            phase_d = PH_HEADER;
            hidx_d  = 3'd0;
          end
        end
        PH_HEADER: begin
          if (hidx_q == 3'd2) begin
            start_d = t_acc;
            if (!valid) herr_d = 1'b1;
          end else if (hidx_q == 3'd3) begin
            step_d = t_acc;
            if (!valid) herr_d = 1'b1;
          end else if (hidx_q == 3'd4) begin
            count_d = cnt_v;
            herr_d  = herr_v;
            phase_d = PH_VALUES;
            seen_d  = 32'd0;
            if (!herr_v) begin
              emit                 = 1'b1;
              tok_item.kind        = lstp_pkg::KIND_HEADER;
              tok_item.start_ticks = start_q;
              tok_item.step_ticks  = step_q;
              tok_item.point_count = cnt_v;
            end
          end
          hidx_d = hidx_q + 3'd1;
        end
        default: begin
          if (!herr_q && seen_q < count_q) begin
            if (!valid) begin
              verr_d = 1'b1;
            end else if (!verr_q) begin
              emit                 = 1'b1;
              tok_item.kind        = lstp_pkg::KIND_DISTANCE;
              tok_item.distance_mm = t_acc;
              tok_item.point_index = seen_q;
            end
          end
          if (seen_q != 32'hFFFF_FFFF) seen_d = seen_q + 32'd1;
        end
      endcase
    end

    if (close) begin
      in_tok_d = 1'b0;
      acc_d    = 32'd0;
      dig_d    = 4'd0;
      inv_d    = 1'b0;
      npos_d   = 3'd0;
      nmis_d   = 1'b0;
    end else begin
      in_tok_d = t_in;
      acc_d    = t_acc;
      dig_d    = t_dig;
      inv_d    = t_inv;
      npos_d   = t_npos;
      nmis_d   = t_nmis;
    end

    // end status, precedence as listed
    if (alive_d == 2'b00 || pos_d < lstp_pkg::PREFIX_LAST_POS) st = lstp_pkg::ST_BAD_PREFIX;
    else if (phase_d != PH_VALUES || seen_d == 32'd0)         st = lstp_pkg::ST_NO_CHANNEL;
    else if (herr_d)                                          st = lstp_pkg::ST_BAD_HEADER;
    else if (seen_d < count_d)                                st = lstp_pkg::ST_TOO_FEW;
    else if (verr_d)                                          st = lstp_pkg::ST_BAD_VALUE;
    else                                                      st = lstp_pkg::ST_OK;
    end_item.kind   = lstp_pkg::KIND_END;
    end_item.status = st;
    end_item.last   = 1'b1;

    if (fin) begin
      pos_d   = 4'd0;
      alive_d = 2'b11;
      phase_d = PH_SEARCH;
      hidx_d  = 3'd0;
      start_d = 32'd0;
      step_d  = 32'd0;
      count_d = 32'd0;
      seen_d  = 32'd0;
      herr_d  = 1'b0;
      verr_d  = 1'b0;
    end

    item0 = emit ? tok_item : end_item;
    if (accept) push_cnt = 2'(emit) + 2'(fin);
    else        push_cnt = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 4'd0;
      alive_q  <= 2'b11;
      phase_q  <= PH_SEARCH;
      in_tok_q <= 1'b0;
      acc_q    <= 32'd0;
      dig_q    <= 4'd0;
      inv_q    <= 1'b0;
      npos_q   <= 3'd0;
      nmis_q   <= 1'b0;
      hidx_q   <= 3'd0;
      start_q  <= 32'd0;
      step_q   <= 32'd0;
      count_q  <= 32'd0;
      seen_q   <= 32'd0;
      herr_q   <= 1'b0;
      verr_q   <= 1'b0;
    end else if (accept) begin
      pos_q    <= pos_d;
      alive_q  <= alive_d;
      phase_q  <= phase_d;
      in_tok_q <= in_tok_d;
      acc_q    <= acc_d;
      dig_q    <= dig_d;
      inv_q    <= inv_d;
      npos_q   <= npos_d;
      nmis_q   <= nmis_d;
      hidx_q   <= hidx_d;
      start_q  <= start_d;
      step_q   <= step_d;
      count_q  <= count_d;
      seen_q   <= seen_d;
      herr_q   <= herr_d;
      verr_q   <= verr_d;
    end
  end

  lstp_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .item0_i    (item0),
    .item1_i    (end_item),
    .room2_o    (room2),
    .pop_i      (m_axis_tready),
    .valid_o    (m_axis_tvalid),
    .item_o     (q_item)
  );

  assign m_axis_tdata = {5'b0, q_item.status, q_item.point_index, q_item.distance_mm,
                         q_item.point_count, q_item.step_ticks, q_item.start_ticks};
  assign m_axis_tuser = q_item.kind;
  assign m_axis_tlast = q_item.last;

endmodule

// ----- rtl/lstp_fifo.sv -----
// ----------------------------------------------------------------------------
// lstp_fifo
// Small result queue: takes up to two items per cycle, hands out one.
// ----------------------------------------------------------------------------
module lstp_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [1:0]                      push_cnt_i,
  input  lstp_pkg::item_t                 item0_i,
  input  lstp_pkg::item_t                 item1_i,
  output logic                            room2_o,
  input  logic                            pop_i,
  output logic                            valid_o,
  output lstp_pkg::item_t                 item_o
);

  lstp_pkg::item_t                   mem_q [lstp_pkg::QDEPTH];
  logic [lstp_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, wr_ptr1;
  logic [lstp_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [lstp_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              do_pop;

  assign valid_o = (cnt_q != '0);
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];
  assign room2_o = (cnt_q <= lstp_pkg::QCNT_W'(lstp_pkg::QDEPTH - 2));
  assign wr_ptr1 = wr_ptr_q + lstp_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + lstp_pkg::QPTR_W'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + lstp_pkg::QPTR_W'(do_pop);
    cnt_d    = cnt_q + lstp_pkg::QCNT_W'(push_cnt_i) - lstp_pkg::QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= item0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr1] <= item1_i;
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench of the scan telegram parser.
// Telegrams go in one byte per item in bursts with random gaps, and results
// leave under a shifting stall pattern. A behavioural parser in the bench
// predicts every header, distance and end status item. Each result is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int RANDOM_BYTES   = 150;

  localparam logic [8*15-1:0] PFX_SSN   = {"sSN LMD", "scandata"};
  localparam logic [8*15-1:0] PFX_SRA   = {"sRA LMD", "scandata"};
  localparam logic [8*5-1:0]  CHAN_NAME = "DIST1";

  typedef enum logic [1:0] {HUNT_CHANNEL, READ_HEADER, READ_VALUES} scan_phase_e;

  typedef enum int {
    FLAW_NONE, FLAW_PREFIX, FLAW_NAME, FLAW_HEADER, FLAW_ZERO_COUNT,
    FLAW_TOO_FEW, FLAW_VALUE, FLAW_CUT, FLAW_NOISE
  } flaw_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [167:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  logic         m_axis_tlast;

  lidar_scan_telegram_parser i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // parser state mirrored by the bench
  logic [3:0]  pfx_pos;
  logic [1:0]  pfx_live;
  scan_phase_e phase;
  logic        in_tok;
  logic [31:0] tok_val;
  logic [3:0]  tok_len;
  logic        tok_bad;
  logic [2:0]  name_pos;
  logic        name_miss;
  logic [2:0]  hdr_idx;
  logic [31:0] start_q;
  logic [31:0] step_q;
  logic [31:0] count_q;
  logic [31:0] n_vals;
  logic        hdr_bad;
  logic        val_bad;

  lstp_pkg::item_t pending_items[$];
  logic [7:0]  tg[$];           // telegram under construction
  int          n_mismatch = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          rx_mode = 0;
  int          rx_mode_left = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] pfx_byte(logic alt, logic [3:0] pos);
    int p;
    p = 14 - int'(pos);
    return alt ? PFX_SRA[8*p +: 8] : PFX_SSN[8*p +: 8];
  endfunction

  function automatic logic [7:0] name_byte(logic [2:0] pos);
    return CHAN_NAME[8*(4 - int'(pos)) +: 8];
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void clear_tok();
    in_tok    = 1'b0;
    tok_val   = '0;
    tok_len   = '0;
    tok_bad   = 1'b0;
    name_pos  = '0;
    name_miss = 1'b0;
  endfunction

  function automatic void reset_scan();
    pfx_pos  = '0;
    pfx_live = 2'b11;
    phase    = HUNT_CHANNEL;
    clear_tok();
    hdr_idx  = '0;
    start_q  = '0;
    step_q   = '0;
    count_q  = '0;
    n_vals   = '0;
    hdr_bad  = 1'b0;
    val_bad  = 1'b0;
  endfunction

  function automatic void push_item(logic [1:0] kind, logic [31:0] st, logic [31:0] sp,
                                    logic [31:0] ct, logic [31:0] ds, logic [31:0] ix,
                                    logic [2:0] stat, logic lst);
    lstp_pkg::item_t it;
    it.kind        = kind;
    it.start_ticks = st;
    it.step_ticks  = sp;
    it.point_count = ct;
    it.distance_mm = ds;
    it.point_index = ix;
    it.status      = stat;
    it.last        = lst;
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic void add_char(logic [7:0] c);
    logic [3:0] nib;
    logic       hexd;
    in_tok = 1'b1;
    hexd   = 1'b1;
    nib    = '0;
    if (c >= "0" && c <= "9") nib = 4'(c - "0");
    else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
    else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
    else hexd = 1'b0;

    if (tok_len < lstp_pkg::DIGIT_SAT) tok_len++;
    if (!hexd || tok_len > lstp_pkg::DIGIT_LIMIT) tok_bad = 1'b1;
    else tok_val = {tok_val[27:0], nib};

    if (name_pos < lstp_pkg::NAME_END_POS && c == name_byte(name_pos)) name_pos++;
    else name_miss = 1'b1;
  endfunction

  function automatic void close_tok();
    logic ok;
    ok = !tok_bad && tok_len != 0;
    if (!in_tok) return;
    if (pfx_live != 0) begin
      case (phase)
        HUNT_CHANNEL: begin
          if (!name_miss && name_pos == lstp_pkg::NAME_END_POS) begin
            phase   = READ_HEADER;
            hdr_idx = '0;
          end
        end
        READ_HEADER: begin
          // fields 0 and 1 are scale and offset, not used
          case (hdr_idx)
            3'd2: begin
              start_q = tok_val;
              if (!ok) hdr_bad = 1'b1;
            end
            3'd3: begin
              step_q = tok_val;
              if (!ok) hdr_bad = 1'b1;
            end
            3'd4: begin
              count_q = ok ? tok_val : '0;
              if (!ok || count_q == 0) hdr_bad = 1'b1;
              phase  = READ_VALUES;
              n_vals = '0;
              if (!hdr_bad)
                push_item(lstp_pkg::KIND_HEADER, start_q, step_q, count_q, '0, '0,
                          lstp_pkg::ST_OK, 1'b0);
            end
            default: ;
          endcase
          hdr_idx++;
        end
        default: begin
          if (!hdr_bad && n_vals < count_q) begin
            if (!ok) val_bad = 1'b1;
            else if (!val_bad)
              push_item(lstp_pkg::KIND_DISTANCE, '0, '0, '0, tok_val, n_vals,
                        lstp_pkg::ST_OK, 1'b0);
          end
          if (n_vals != '1) n_vals++;
        end
      endcase
    end
    clear_tok();
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic fin);
    logic [2:0] stat;
    if (pfx_pos < lstp_pkg::PREFIX_LAST_POS) begin
      if (c != pfx_byte(1'b0, pfx_pos)) pfx_live[0] = 1'b0;
      if (c != pfx_byte(1'b1, pfx_pos)) pfx_live[1] = 1'b0;
      pfx_pos++;
    end
    if (is_ws(c)) close_tok();
    else add_char(c);
    if (fin) begin
      close_tok();
      if (pfx_live == 0 || pfx_pos < lstp_pkg::PREFIX_LAST_POS)
        stat = lstp_pkg::ST_BAD_PREFIX;
      else if (phase != READ_VALUES || n_vals == 0) stat = lstp_pkg::ST_NO_CHANNEL;
      else if (hdr_bad) stat = lstp_pkg::ST_BAD_HEADER;
      else if (n_vals < count_q) stat = lstp_pkg::ST_TOO_FEW;
      else if (val_bad) stat = lstp_pkg::ST_BAD_VALUE;
      else stat = lstp_pkg::ST_OK;
      push_item(lstp_pkg::KIND_END, '0, '0, '0, '0, '0, stat, 1'b1);
      reset_scan();
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    n_mismatch++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  always @(posedge clk_i) begin : monitor
    lstp_pkg::item_t want;
    if (!rst_ni) begin
      reset_scan();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_items.size() == 0) begin
          report_mismatch($sformatf("item with nothing expected, kind %0d", m_axis_tuser));
        end else begin
          want = pending_items.pop_front();
          check_field("kind",        m_axis_tuser,           want.kind);
          check_field("start_ticks", m_axis_tdata[31:0],     want.start_ticks);
          check_field("step_ticks",  m_axis_tdata[63:32],    want.step_ticks);
          check_field("point_count", m_axis_tdata[95:64],    want.point_count);
          check_field("distance_mm", m_axis_tdata[127:96],   want.distance_mm);
          check_field("point_index", m_axis_tdata[159:128],  want.point_index);
          check_field("status",      m_axis_tdata[162:160],  want.status);
          check_field("last",        m_axis_tlast,           want.last);
        end
      end
      if (s_axis_tvalid && s_axis_tready) parse_byte(s_axis_tdata, s_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // receiver: ready pattern switches between four randomly chosen modes
  always @(negedge clk_i) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 120);
    end
    rx_mode_left--;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_mode_left % 16 == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Telegram construction
  // --------------------------------------------------------------------------
  function automatic void tg_add(logic [7:0] b);
    tg.insert(tg.size(), b);
  endfunction

  function automatic void put_lit(string s);
    for (int i = 0; i < s.len(); i++) tg_add(s[i]);
  endfunction

  function automatic void put_prefix(logic alt);
    for (int i = 0; i < 15; i++) tg_add(pfx_byte(alt, 4'(i)));
  endfunction

  // nd digits of v, most significant first, digits past the eighth are zero
  function automatic void put_hex(logic [31:0] v, int nd);
    logic [3:0] nib;
    for (int i = nd - 1; i >= 0; i--) begin
      nib = (i < 8) ? v[4*i +: 4] : 4'h0;
      if (nib < 10) tg_add(8'h30 + 8'(nib));
      else if ($urandom_range(0, 1)) tg_add(8'h37 + 8'(nib));
      else tg_add(8'h57 + 8'(nib));
    end
  endfunction

  function automatic void put_ws();
    logic [7:0] blanks[6];
    blanks = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    repeat ($urandom_range(0, 3) == 0 ? 2 : 1) begin
      if ($urandom_range(0, 3) == 0) tg_add(blanks[$urandom_range(0, 5)]);
      else tg_add(8'h20);
    end
  endfunction

  function automatic void put_near_name();
    case ($urandom_range(0, 4))
      0:       put_lit("DIST");
      1:       put_lit("DIST2");
      2:       put_lit("DIST11");
      3:       put_lit("dist1");
      default: put_lit("DDIST1");
    endcase
  endfunction

  function automatic void put_bad_token();
    case ($urandom_range(0, 3))
      0: begin
        put_lit("G");
        put_hex($urandom, $urandom_range(1, 3));
      end
      1: put_hex($urandom, $urandom_range(9, 12));
      2: begin
        put_hex($urandom, $urandom_range(1, 3));
        tg_add(8'h00);
      end
      default: tg_add(8'h80 | 8'($urandom_range(0, 127)));
    endcase
  endfunction

  function automatic void put_filler();
    case ($urandom_range(0, 3))
      0: put_hex($urandom, $urandom_range(1, 8));
      1: put_near_name();
      2: put_lit("sRA");
      default: repeat ($urandom_range(1, 4)) tg_add(8'($urandom_range(33, 126)));
    endcase
  endfunction

  function automatic void put_value();
    put_hex($urandom, ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(1, 4));
  endfunction

  function automatic void build_scan(flaw_e flaw);
    int          bad_hdr;
    int          bad_val;
    int          n_given;
    int          i;
    logic [31:0] cnt;
    bad_hdr = (flaw == FLAW_HEADER) ? $urandom_range(0, 2) : -1;
    put_prefix(1'($urandom_range(0, 1)));
    if (flaw == FLAW_PREFIX) begin
      i = $urandom_range(0, 14);
      tg[i] = tg[i] ^ (8'h01 << $urandom_range(0, 7));
    end
    repeat ($urandom_range(0, 2)) begin
      put_ws();
      put_filler();
    end
    put_ws();
    if (flaw == FLAW_NAME) put_near_name();
    else put_lit("DIST1");
    put_ws();
    put_hex($urandom, $urandom_range(1, 8));
    put_ws();
    put_hex($urandom, $urandom_range(1, 8));

    n_given = $urandom_range(1, 6);
    cnt     = n_given;
    if (flaw == FLAW_TOO_FEW)
      cnt = ($urandom_range(0, 3) == 0) ? ($urandom | 32'h10) : n_given + $urandom_range(1, 8);
    if (flaw == FLAW_ZERO_COUNT) cnt = '0;
    // start, step, count
    for (i = 0; i < 3; i++) begin
      put_ws();
      if (i == bad_hdr) put_bad_token();
      else if (i == 2) put_hex(cnt, (cnt < 16) ? $urandom_range(1, 8) : 8);
      else put_hex($urandom, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 8);
    end
    if (flaw == FLAW_CUT) begin
      if ($urandom_range(0, 1)) put_ws();
      return;
    end

    bad_val = (flaw == FLAW_VALUE) ? $urandom_range(0, n_given - 1) : -1;
    for (i = 0; i < n_given; i++) begin
      put_ws();
      if (i == bad_val) put_bad_token();
      else put_value();
    end
    repeat ($urandom_range(0, 2)) begin
      put_ws();
      if ($urandom_range(0, 2) == 0) put_bad_token();
      else put_filler();
    end
    if ($urandom_range(0, 1)) put_ws();
  endfunction

  function automatic void build_noise();
    if ($urandom_range(0, 2) == 0) put_prefix(1'($urandom_range(0, 1)));
    repeat ($urandom_range(1, 30)) tg_add(8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic fin);
    @(negedge clk_i);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_telegram();
    for (int i = 0; i < tg.size(); i++) send_byte(tg[i], i == tg.size() - 1);
    tg.delete();
  endtask

  // hold the input back until every predicted item has left the block
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_good_scans();
    put_prefix(1'b0);
    put_lit(" 1 DIST1 3F800000 00000000 0 1388 3 A 1f 0FF");
    send_telegram();
    // negative start, zero step, ends on a blank
    put_prefix(1'b1);
    put_lit("\tDIST1\t1 0 FFFFFFFF 00000000 00000001 ffffffff ");
    send_telegram();
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 80000000 FFFFFFFF 2 0 00000000");
    send_telegram();
  endtask

  task automatic test_prefix_errors();
    put_lit("x");
    send_telegram();
    put_lit("sSN LMD");
    send_telegram();
    // each byte matches one alternative, together neither
    put_lit("sRN LMD");
    put_lit("scandata DIST1 1 0 0 1 1 5");
    send_telegram();
    put_prefix(1'b1);
    send_telegram();
  endtask

  task automatic test_header_errors();
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 12G4 10 2 5 6");
    send_telegram();
    put_prefix(1'b1);
    put_lit(" DIST1 1 0 0 10 000000002 5 6");
    send_telegram();
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 0 10 0 5");
    send_telegram();
    // channel found but header incomplete
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 0 10");
    send_telegram();
  endtask

  task automatic test_value_errors();
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 0 10 5 1 2");
    send_telegram();
    put_prefix(1'b1);
    put_lit(" DIST1 1 0 0 10 3 1 zz 3");
    send_telegram();
    // bad token past the announced count is not checked
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 0 10 2 1 2 zz");
    send_telegram();
    // header goes out, then no value token at all
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 0 10 2");
    send_telegram();
    put_prefix(1'b1);
    put_lit(" DIST1 1 0 0 10 2 123456789 5");
    send_telegram();
  endtask

  task automatic test_token_rules();
    put_prefix(1'b0);
    put_lit("\015\nDIST1\013\0141 0\t0 10 1 7\n");
    send_telegram();
    put_prefix(1'b1);
    put_lit(" DIST1 1 0 0 10 2 ");
    tg_add(8'h00);
    put_lit("1 2");
    send_telegram();
    put_prefix(1'b0);
    put_lit(" DIST1 1 0 0 10 1 ");
    tg_add(8'hFF);
    send_telegram();
    // second channel name is just the scale field
    put_prefix(1'b1);
    put_lit(" DIST1 DIST1 1 0 0 1 1 9");
    send_telegram();
  endtask

  task automatic test_random_scans();
    int    sent;
    int    r;
    flaw_e flaw;
    sent = 0;
    drain_results();
    while (sent < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      flaw = (r < 55) ? FLAW_NONE : flaw_e'(1 + (r - 55) % 8);
      if (flaw == FLAW_NOISE) begin
        build_noise();
      end else begin
        build_scan(flaw);
      end
      sent += tg.size();
      if ($urandom_range(0, 7) == 0) drain_results();
      send_telegram();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_good_scans();
    test_prefix_errors();
    test_header_errors();
    test_value_errors();
    test_token_rules();
    test_random_scans();

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_mismatch == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
